>>> rtl/mfh_pkg.sv
// Shared constants and types for the meter frame hunter.
`timescale 1ns / 1ps

package mfh_pkg;

  // Sizing
  localparam int BUFFER_BYTES = 512;
  localparam int TRACKERS     = 16;
  localparam int HELD_W       = $clog2(BUFFER_BYTES + 2);

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 9;
  localparam int SKIP_W     = 9;
  localparam int FLEN_W     = 9;
  localparam int ADDR_BYTES = 6;
  localparam int ADDR_W     = ADDR_BYTES * BYTE_W;

  // Stream word widths
  localparam int S_TDATA_W  = 8;
  localparam int M_FIELDS_W = 1 + FLEN_W + SKIP_W + ADDR_W + 3 * BYTE_W - 8 + 3;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Link markers
  localparam logic [BYTE_W-1:0] START_MARK = 8'h68;
  localparam logic [BYTE_W-1:0] END_MARK   = 8'h16;
  localparam int                ERROR_BIT  = 6;

  // Frame offsets
  localparam logic [OFF_W-1:0] OFF_FIRST  = 9'd1;
  localparam logic [OFF_W-1:0] OFF_MARK2  = 9'd7;
  localparam logic [OFF_W-1:0] OFF_CTRL   = 9'd8;
  localparam logic [OFF_W-1:0] OFF_LEN    = 9'd9;
  localparam logic [OFF_W-1:0] OFF_CSUM   = 9'd10;
  localparam logic [OFF_W-1:0] OFF_TAIL   = 9'd11;
  localparam logic [SKIP_W-1:0] SKIP_MAX  = '1;
  localparam logic [FLEN_W-1:0] FRAME_OVH = 9'd12;

  // Per-step command broadcast to all trackers
  typedef struct packed {
    logic              step;
    logic              clear;
    logic [BYTE_W-1:0] rx_byte;
    logic [SKIP_W-1:0] skip;
  } trk_cmd_t;

  // Header fields captured by one tracker
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] ctrl;
    logic [BYTE_W-1:0] len;
    logic [SKIP_W-1:0] skip;
  } trk_info_t;

endpackage

>>> rtl/mfh_tracker.sv
// One candidate-frame tracker: follows a frame from its start byte to the end mark.
`timescale 1ns / 1ps

module mfh_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfh_pkg::trk_cmd_t cmd_i,
  input  logic              alloc_i,
  output logic              busy_o,
  output logic              done_o,
  output mfh_pkg::trk_info_t info_o
);

  logic                            busy_q, busy_d;
  logic [mfh_pkg::OFF_W-1:0]       off_q, off_d;
  logic [mfh_pkg::BYTE_W-1:0]      sum_q, sum_d;
  mfh_pkg::trk_info_t              info_q, info_d;

  logic [mfh_pkg::BYTE_W-1:0]      len_eff;
  logic [mfh_pkg::OFF_W-1:0]       chk_pos;
  logic [mfh_pkg::OFF_W-1:0]       end_pos;
  logic                            at_chk;
  logic                            at_end;
  logic                            kill;
  logic [mfh_pkg::BYTE_W-1:0]      b;

  assign b       = cmd_i.rx_byte;
  assign len_eff = (off_q == mfh_pkg::OFF_LEN) ? b : info_q.len;
  assign chk_pos = {1'b0, len_eff} + mfh_pkg::OFF_CSUM;
  assign end_pos = {1'b0, len_eff} + mfh_pkg::OFF_TAIL;
  assign at_chk  = (off_q >= mfh_pkg::OFF_CSUM) && (off_q == chk_pos);
  assign at_end  = (off_q >= mfh_pkg::OFF_CSUM) && (off_q == end_pos);
  assign kill    = ((off_q == mfh_pkg::OFF_MARK2) && (b != mfh_pkg::START_MARK)) ||
                   (at_chk && (b != sum_q));

  assign done_o = cmd_i.step && busy_q && at_end && (b == mfh_pkg::END_MARK);
  // still busy once the current byte has been consumed
  assign busy_o = busy_q && !(cmd_i.step && (kill || at_end));
  assign info_o = info_q;

  always_comb begin
    busy_d = busy_q;
    off_d  = off_q;
    sum_d  = sum_q;
    info_d = info_q;
    if (cmd_i.step) begin
      if (cmd_i.clear) begin
        busy_d = 1'b0;
      end else if (alloc_i) begin
        busy_d      = 1'b1;
        off_d       = mfh_pkg::OFF_FIRST;
        sum_d       = mfh_pkg::START_MARK;
        info_d.skip = cmd_i.skip;
      end else if (busy_q) begin
        if (kill || at_end) begin
          busy_d = 1'b0;
        end else begin
          sum_d = sum_q + b;
          off_d = off_q + mfh_pkg::OFF_W'(1);
          for (int k = 0; k < mfh_pkg::ADDR_BYTES; k++) begin
            if (off_q == mfh_pkg::OFF_W'(k + 1)) info_d.addr[8*k +: 8] = b;
          end
          if (off_q == mfh_pkg::OFF_CTRL) info_d.ctrl = b;
          if (off_q == mfh_pkg::OFF_LEN)  info_d.len  = b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    sum_q  <= sum_d;
    info_q <= info_d;
  end

endmodule

>>> rtl/mfh_arbiter.sv
// Tracker arbitration: oldest completing tracker wins, lowest free tracker is allocated.
`timescale 1ns / 1ps

module mfh_arbiter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mfh_pkg::TRACKERS-1:0] busy_i,
  input  logic [mfh_pkg::TRACKERS-1:0] done_i,
  input  logic                         alloc_req_i,
  output logic [mfh_pkg::TRACKERS-1:0] win_o,
  output logic                         any_done_o,
  output logic [mfh_pkg::TRACKERS-1:0] alloc_o,
  output logic                         full_o
);

  // older_q[i][j]: tracker i was started before tracker j
  logic [mfh_pkg::TRACKERS-1:0][mfh_pkg::TRACKERS-1:0] older_q, older_d;
  logic [mfh_pkg::TRACKERS-1:0] free;
  logic [mfh_pkg::TRACKERS-1:0] first_free;

  assign free       = ~busy_i;
  assign first_free = free & (~free + mfh_pkg::TRACKERS'(1));
  assign full_o     = &busy_i;
  assign any_done_o = |done_i;
  assign alloc_o    = (alloc_req_i && !full_o) ? first_free : '0;

  always_comb begin
    for (int i = 0; i < mfh_pkg::TRACKERS; i++) begin
      win_o[i] = done_i[i];
      for (int j = 0; j < mfh_pkg::TRACKERS; j++) begin
        if (done_i[j] && older_q[j][i]) win_o[i] = 1'b0;
      end
    end
  end

  // A new tracker is younger than every other one
  always_comb begin
    older_d = older_q;
    for (int s = 0; s < mfh_pkg::TRACKERS; s++) begin
      if (alloc_o[s]) begin
        for (int j = 0; j < mfh_pkg::TRACKERS; j++) begin
          older_d[s][j] = 1'b0;
          if (j != s) older_d[j][s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
    end else begin
      older_q <= older_d;
    end
  end

endmodule

>>> rtl/meter_frame_hunter_unit.sv
// Top level of the meter frame hunter: byte stream in, one status word out per byte.
`timescale 1ns / 1ps

// Meter frame hunter. Takes one received meter-link byte per input word and
// returns exactly one result word per byte. Every 0x68 byte opens a candidate
// frame; a bank of TRACKERS parallel trackers follows the open candidates.
// A candidate survives only if byte 7 is 0x68, the byte at 10+len matches the
// mod-256 sum of all earlier frame bytes and the byte at 11+len is 0x16. When
// frames complete on the same byte the earliest start wins; its address,
// control, length, skipped junk count (saturated at 511) and the control 0x40
// error flag are reported and all trackers and the byte count are cleared.
// If more than BUFFER_BYTES bytes are held without a frame, everything is
// cleared, no candidate opens on that byte and buffer_cleared is set. A start
// byte arriving with all trackers busy is dropped and flagged by tracker_overflow.
// Timing: one input register and one output register; the trackers update as
// each result word is registered. Throughput is one byte per cycle while the
// output is not stalled, set by the tracker update and arbitration logic.
// Input is accepted while a finished word waits if the input register is empty.
// No configuration registers.

module meter_frame_hunter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // rx_byte[7:0]
  input  logic [mfh_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // frame_found[0], frame_length[9:1], skipped_bytes[18:10], station_address[66:19],
  // control_code[74:67], data_length[82:75], error_reply[83], buffer_cleared[84],
  // tracker_overflow[85], zero fill[87:86]
  output logic [mfh_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i
);

  localparam int T = mfh_pkg::TRACKERS;

  // Input stage
  logic                          in_v_q, in_v_d;
  logic [mfh_pkg::BYTE_W-1:0]    in_byte_q;
  logic                          adv;
  logic                          proc;

  // Output stage
  logic                          out_v_q, out_v_d;
  logic [mfh_pkg::M_TDATA_W-1:0] out_data_q;
  logic [mfh_pkg::M_TDATA_W-1:0] out_data_d;

  // Held byte count
  logic [mfh_pkg::HELD_W-1:0]    held_q, held_d;
  logic [mfh_pkg::HELD_W-1:0]    held_inc;
  logic                          buf_over;
  logic [mfh_pkg::SKIP_W-1:0]    skip_sat;

  // Trackers
  mfh_pkg::trk_cmd_t             cmd;
  mfh_pkg::trk_info_t            info [T];
  mfh_pkg::trk_info_t            win_info;
  logic [T-1:0]                  busy;
  logic [T-1:0]                  done;
  logic [T-1:0]                  win;
  logic [T-1:0]                  alloc;
  logic                          any_done;
  logic                          full;
  logic                          is_start;
  logic                          alloc_req;

  // Handshake: output register drains, input register refills in the same cycle
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_v_q || adv;
  assign proc            = in_v_q && adv;

  assign held_inc = held_q + mfh_pkg::HELD_W'(1);
  assign buf_over = held_inc > mfh_pkg::HELD_W'(mfh_pkg::BUFFER_BYTES);
  assign skip_sat = (held_q > mfh_pkg::HELD_W'(mfh_pkg::SKIP_MAX)) ?
                    mfh_pkg::SKIP_MAX : held_q[mfh_pkg::SKIP_W-1:0];

  // Trackers that die on this byte count as free for a new start
  assign is_start  = (in_byte_q == mfh_pkg::START_MARK);
  assign alloc_req = proc && is_start && !any_done && !buf_over;

  assign cmd.step    = proc;
  assign cmd.clear   = any_done || buf_over;
  assign cmd.rx_byte = in_byte_q;
  assign cmd.skip    = skip_sat;

  for (genvar t = 0; t < T; t++) begin : g_trk
    mfh_tracker u_trk (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .alloc_i (alloc[t]),
      .busy_o  (busy[t]),
      .done_o  (done[t]),
      .info_o  (info[t])
    );
  end

  mfh_arbiter u_arb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_i      (busy),
    .done_i      (done),
    .alloc_req_i (alloc_req),
    .win_o       (win),
    .any_done_o  (any_done),
    .alloc_o     (alloc),
    .full_o      (full)
  );

  // Winner is one-hot (or empty), so an AND-OR mux suffices
  always_comb begin
    win_info = '0;
    for (int t = 0; t < T; t++) begin
      if (win[t]) win_info = win_info | info[t];
    end
  end

  always_comb begin
    out_data_d = '0;
    if (any_done) begin
      out_data_d[0]     = 1'b1;
      out_data_d[9:1]   = {1'b0, win_info.len} + mfh_pkg::FRAME_OVH;
      out_data_d[18:10] = win_info.skip;
      out_data_d[66:19] = win_info.addr;
      out_data_d[74:67] = win_info.ctrl;
      out_data_d[82:75] = win_info.len;
      out_data_d[83]    = win_info.ctrl[mfh_pkg::ERROR_BIT];
    end else if (buf_over) begin
      out_data_d[84]    = 1'b1;
    end else if (is_start && full) begin
      out_data_d[85]    = 1'b1;
    end
  end

  always_comb begin
    in_v_d  = in_v_q;
    out_v_d = out_v_q;
    held_d  = held_q;
    if (s_axis_tready_o) in_v_d = s_axis_tvalid_i;
    if (adv)             out_v_d = in_v_q;
    if (proc) begin
      held_d = (any_done || buf_over) ? '0 : held_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      held_q  <= '0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q  <= s_axis_tdata_i;
    if (proc)                               out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
